// ----- hdl/jwd_pkg.sv -----
// Shared constants for the Jensen wake deficit block.
`default_nettype none
package jwd_pkg;
   // Default width of the Q16.8 distance fields
   localparam int DIST_BITS_DEF = 24;
   // Reset value of the wake expansion rate, Q0.16
   localparam logic [15:0] KEXP_RESET = 16'd4915;
   // Log2 depth of the queue between front and back
   localparam int QUEUE_LOG_DEF = 2;
   // Steps of the square-root and divider sections
   localparam int SQRT_STEPS = 17;
   localparam int FDIV_STEPS = 16;
endpackage
`default_nettype wire

// ----- hdl/jensen_wake_deficit.sv -----
// Jensen wake velocity deficit: each accepted query passes the front, the queue and the back to the result ports.
// Throughput one query per cycle; the back pipeline stalls as a whole while a result waits.
// Front (2 stages) and back (37 stages) are parted by a 4-entry queue.
// Synchronous active-high reset empties all stages and sets wake_expansion to 4915.
`default_nettype none
module jensen_wake_deficit #(
   parameter int DIST_BITS = jwd_pkg::DIST_BITS_DEF,
   parameter int QUEUE_LOG = jwd_pkg::QUEUE_LOG_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [15:0]          req_thrust_coeff,
   input  wire logic [15:0]          req_inflow_speed,
   input  wire logic [DIST_BITS-1:0] req_rotor_radius,
   input  wire logic [DIST_BITS-1:0] req_downstream_dist,
   input  wire logic [DIST_BITS-1:0] req_transverse_dist,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [15:0]               rsp_deficit,
   output logic                      rsp_status,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [15:0]          csr_wake_expansion
);
   localparam int ENT_W = 2*DIST_BITS + 35;

   logic             f_valid, q_full, q_empty, b_take;
   logic [ENT_W-1:0] f_data, q_data;

   jwd_front #(.DIST_BITS(DIST_BITS), .ENT_W(ENT_W)) u_front (
      .clock, .reset, .req_push, .req_full, .req_thrust_coeff, .req_inflow_speed,
      .req_rotor_radius, .req_downstream_dist, .req_transverse_dist,
      .csr_valid, .csr_ready, .csr_wake_expansion,
      .out_valid(f_valid), .out_ready(!q_full), .out_data(f_data)
   );

   jwd_queue #(.WIDTH(ENT_W), .DEPTH_LOG(QUEUE_LOG)) u_queue (
      .clock, .reset, .push(f_valid), .wr_data(f_data), .full(q_full),
      .pop(b_take), .rd_data(q_data), .empty(q_empty)
   );

   jwd_back #(.DIST_BITS(DIST_BITS), .ENT_W(ENT_W)) u_back (
      .clock, .reset, .in_valid(!q_empty), .in_take(b_take), .in_data(q_data),
      .rsp_empty, .rsp_pop, .rsp_deficit, .rsp_status
   );
endmodule
`default_nettype wire

// ----- hdl/jwd_queue.sv -----
// Small register queue that decouples the front from the back.
`default_nettype none
module jwd_queue #(
   parameter int WIDTH     = 8,
   parameter int DEPTH_LOG = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);
   localparam int DEPTH = 1 << DEPTH_LOG;

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [DEPTH_LOG-1:0] wr_ptr_ff;
   logic [DEPTH_LOG-1:0] rd_ptr_ff;
   logic [DEPTH_LOG:0]   count_ff;
   logic                 wr_en;
   logic                 rd_en;

   assign full    = (count_ff == (DEPTH_LOG+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_en   = push && !full;
   assign rd_en   = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (wr_en && !rd_en) count_ff <= count_ff + 1'b1;
         else if (rd_en && !wr_en) count_ff <= count_ff - 1'b1;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_data;
   end
endmodule
`default_nettype wire

// ----- hdl/jwd_front.sv -----
// Front end: takes queries, holds the expansion rate, classifies and forms the wake radius.
`default_nettype none
module jwd_front #(
   parameter int DIST_BITS = jwd_pkg::DIST_BITS_DEF,
   parameter int ENT_W     = 2*DIST_BITS + 35
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [15:0]          req_thrust_coeff,
   input  wire logic [15:0]          req_inflow_speed,
   input  wire logic [DIST_BITS-1:0] req_rotor_radius,
   input  wire logic [DIST_BITS-1:0] req_downstream_dist,
   input  wire logic [DIST_BITS-1:0] req_transverse_dist,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [15:0]          csr_wake_expansion,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [ENT_W-1:0]          out_data
);
   logic [15:0]          kexp_ff;
   logic                 vld1_ff, vld2_ff;
   logic [15:0]          ct1_ff, u1_ff, ct2_ff, u2_ff;
   logic [DIST_BITS-1:0] r1_ff, x1_ff, t1_ff, r2_ff, t2_ff, kx2_ff;
   logic                 inval2_ff, xle2_ff;
   logic                 enable;
   logic                 inval_in, xle_in;
   logic [DIST_BITS+15:0] kx_prod;
   logic [DIST_BITS:0]   wake_r;
   logic                 outside;

   assign csr_ready = 1'b1;
   assign enable    = !vld2_ff || out_ready;
   assign req_full  = !enable;

   // expansion rate register
   always_ff @(posedge clock) begin
      if (reset) kexp_ff <= jwd_pkg::KEXP_RESET;
      else if (csr_valid) kexp_ff <= csr_wake_expansion;
   end

   // classification and k*x on the first stage
   assign inval_in = (u1_ff == '0) || (r1_ff == '0) || (kexp_ff == '0);
   assign xle_in   = x1_ff[DIST_BITS-1] || (x1_ff == '0);
   assign kx_prod  = kexp_ff * x1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (enable) begin
         vld1_ff <= req_push;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ct1_ff    <= req_thrust_coeff;
         u1_ff     <= req_inflow_speed;
         r1_ff     <= req_rotor_radius;
         x1_ff     <= req_downstream_dist;
         t1_ff     <= req_transverse_dist;
         ct2_ff    <= ct1_ff;
         u2_ff     <= u1_ff;
         r2_ff     <= r1_ff;
         t2_ff     <= t1_ff;
         kx2_ff    <= kx_prod[DIST_BITS+15:16];
         inval2_ff <= inval_in;
         xle2_ff   <= xle_in;
      end
   end

   // wake radius and edge test; an exact hit on the edge is inside
   assign wake_r   = {1'b0, r2_ff} + {1'b0, kx2_ff};
   assign outside  = ({1'b0, t2_ff} > wake_r);
   assign out_valid = vld2_ff;
   assign out_data = {ct2_ff, u2_ff, r2_ff, wake_r, xle2_ff || outside, inval2_ff};
endmodule
`default_nettype wire

// ----- hdl/jwd_back.sv -----
// Back end: square root, two dividers and the deficit products in a stalling pipeline.
`default_nettype none
module jwd_back #(
   parameter int DIST_BITS = jwd_pkg::DIST_BITS_DEF,
   parameter int ENT_W     = 2*DIST_BITS + 35
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_take,
   input  wire logic [ENT_W-1:0] in_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [15:0]           rsp_deficit,
   output logic                  rsp_status
);
   localparam int SQ_END = jwd_pkg::SQRT_STEPS;
   localparam int FD_END = SQ_END + 1 + jwd_pkg::FDIV_STEPS;
   localparam int NST    = FD_END + 3;

   typedef struct packed {
      logic [15:0]        ct;
      logic [15:0]        u;
      logic [DIST_BITS:0] w;
      logic               kill;
      logic               status;
      logic [33:0]        sq_v;
      logic [18:0]        sq_rem;
      logic [16:0]        sq_root;
      logic [DIST_BITS:0] qd_rem;
      logic [16:0]        qd_sh;
      logic [16:0]        qd_q;
      logic [17:0]        fd_d;
      logic [17:0]        fd_rem;
      logic [15:0]        fd_q;
      logic [16:0]        q2;
      logic [15:0]        uf;
      logic [15:0]        d;
   } stage_type;

   stage_type          pipe_ff [NST];
   stage_type          pipe_in [NST];
   logic [NST-1:0]     vld_ff;
   logic               enable;
   logic [15:0]        e_ct, e_u;
   logic [DIST_BITS-1:0] e_r;
   logic [DIST_BITS:0] e_w;
   logic               e_kill, e_status;

   assign {e_ct, e_u, e_r, e_w, e_kill, e_status} = in_data;
   assign enable    = !vld_ff[NST-1] || rsp_pop;
   assign in_take   = in_valid && enable;
   assign rsp_empty = !vld_ff[NST-1];
   assign rsp_deficit = pipe_ff[NST-1].d;
   assign rsp_status  = pipe_ff[NST-1].status;

   // stage logic
   always_comb begin
      logic [20:0]        sq_t, sq_trial;
      logic [DIST_BITS+1:0] qd_t;
      logic [18:0]        fd_t;
      logic [33:0]        qq;
      logic [31:0]        uf_p;
      logic [32:0]        d_p;
      stage_type          s;
      // stage 0 loads from the queue
      s         = '0;
      s.ct      = e_ct;
      s.u       = e_u;
      s.w       = e_w;
      s.kill    = e_kill;
      s.status  = e_status;
      s.sq_v    = {1'b0, 17'h10000 - {1'b0, e_ct}, 16'b0};
      s.qd_rem  = {2'b0, e_r[DIST_BITS-1:1]};
      s.qd_sh   = {e_r[0], 16'b0};
      pipe_in[0] = s;
      for (int i = 0; i < NST-1; i++) begin
         s = pipe_ff[i];
         if (i < SQ_END) begin
            // one root digit and one r/w quotient bit
            sq_t     = {s.sq_rem, s.sq_v[33:32]};
            sq_trial = {2'b0, s.sq_root, 2'b01};
            if (sq_t >= sq_trial) begin
               s.sq_rem  = 19'(sq_t - sq_trial);
               s.sq_root = {s.sq_root[15:0], 1'b1};
            end else begin
               s.sq_rem  = sq_t[18:0];
               s.sq_root = {s.sq_root[15:0], 1'b0};
            end
            s.sq_v = {s.sq_v[31:0], 2'b00};
            qd_t = {s.qd_rem, s.qd_sh[16]};
            if (qd_t >= {1'b0, s.w}) begin
               s.qd_rem = (DIST_BITS+1)'(qd_t - {1'b0, s.w});
               s.qd_q   = {s.qd_q[15:0], 1'b1};
            end else begin
               s.qd_rem = qd_t[DIST_BITS:0];
               s.qd_q   = {s.qd_q[15:0], 1'b0};
            end
            s.qd_sh = {s.qd_sh[15:0], 1'b0};
         end else if (i == SQ_END) begin
            // set up ct/(1+s) and square the radius ratio
            s.fd_d   = 18'h10000 + {1'b0, s.sq_root};
            s.fd_rem = {2'b0, s.ct};
            qq       = s.qd_q * s.qd_q;
            s.q2     = qq[32:16];
         end else if (i < FD_END) begin
            // one quotient bit of ct/(1+s)
            fd_t = {s.fd_rem, 1'b0};
            if (fd_t >= {1'b0, s.fd_d}) begin
               s.fd_rem = 18'(fd_t - {1'b0, s.fd_d});
               s.fd_q   = {s.fd_q[14:0], 1'b1};
            end else begin
               s.fd_rem = fd_t[17:0];
               s.fd_q   = {s.fd_q[14:0], 1'b0};
            end
         end else if (i == FD_END) begin
            uf_p = s.u * s.fd_q;
            s.uf = uf_p[31:16];
         end else begin
            // final product, forced to zero for invalid or unaffected points
            d_p = s.uf * s.q2;
            s.d = (s.kill || s.status) ? 16'd0 : d_p[31:16];
         end
         pipe_in[i+1] = s;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (enable) vld_ff <= {vld_ff[NST-2:0], in_valid};
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < NST; i++) pipe_ff[i] <= pipe_in[i];
      end
   end
endmodule
`default_nettype wire

// ----- bench/jensen_wake_deficit_chk.sv -----
// Checker for the Jensen wake deficit block: watches all channels, predicts and compares.
module jensen_wake_deficit_chk (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire logic [15:0] req_thrust_coeff,
   input  wire logic [15:0] req_inflow_speed,
   input  wire logic [23:0] req_rotor_radius,
   input  wire logic [23:0] req_downstream_dist,
   input  wire logic [23:0] req_transverse_dist,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   input  wire logic [15:0] rsp_deficit,
   input  wire logic        rsp_status,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [15:0] csr_wake_expansion,
   output int               fail_count,
   output int               pending
);
   typedef struct packed {
      logic [15:0] deficit;
      logic        status;
   } wake_result_type;

   wake_result_type deficit_q[$];
   logic [15:0]     kexp;

   assign pending = deficit_q.size();

   // Truncated integer square root, bit by bit
   function automatic logic [63:0] root_trunc(input logic [63:0] v);
      logic [63:0] acc;
      logic [63:0] bitv;
      acc  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= acc + bitv) begin
            v   = v - (acc + bitv);
            acc = (acc >> 1) + bitv;
         end else begin
            acc = acc >> 1;
         end
         bitv = bitv >> 2;
      end
      return acc;
   endfunction

   // Expected deficit and status for one query
   function automatic wake_result_type wake_deficit(
      input logic [15:0] ct, input logic [15:0] u, input logic [23:0] r,
      input logic [23:0] x, input logic [23:0] t, input logic [15:0] k);
      wake_result_type res;
      logic [63:0]     sq, fr, wr, qr, q2;
      res = '0;
      if (u == 0 || r == 0 || k == 0) begin
         res.status = 1'b1;
      end else if (!x[23] && x != 0) begin
         wr = 64'(r) + ((64'(k) * 64'(x)) >> 16);
         if (64'(t) <= wr) begin
            sq = root_trunc((64'd65536 - 64'(ct)) << 16);
            fr = (64'(ct) << 16) / (64'd65536 + sq);
            qr = (64'(r) << 16) / wr;
            q2 = (qr * qr) >> 16;
            res.deficit = 16'((((64'(u) * fr) >> 16) * q2) >> 16);
         end
      end
      return res;
   endfunction

   // Track register writes, predict on each query, compare on each result
   always @(posedge clock) begin
      wake_result_type want;
      if (reset) begin
         kexp       <= 16'd4915;
         fail_count <= 0;
         deficit_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (deficit_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result %h/%b", rsp_deficit, rsp_status);
            end else begin
               want = deficit_q.pop_front();
               if (want.deficit !== rsp_deficit || want.status !== rsp_status) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected deficit %h status %b, got %h %b",
                              want.deficit, want.status, rsp_deficit, rsp_status);
               end
            end
         end
         if (req_push && !req_full)
            deficit_q.push_back(wake_deficit(req_thrust_coeff, req_inflow_speed,
               req_rotor_radius, req_downstream_dist, req_transverse_dist, kexp));
         if (csr_valid && csr_ready) kexp <= csr_wake_expansion;
      end
   end
endmodule

// ----- bench/jensen_wake_deficit_tb.sv -----
// Testbench top for the Jensen wake deficit block: stimulus, idling and verdict.
module jensen_wake_deficit_tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [15:0] req_thrust_coeff = 0;
   logic [15:0] req_inflow_speed = 0;
   logic [23:0] req_rotor_radius = 0;
   logic [23:0] req_downstream_dist = 0;
   logic [23:0] req_transverse_dist = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [15:0] rsp_deficit;
   logic        rsp_status;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_wake_expansion = 0;
   int          fail_count;
   int          pending;
   bit          send_done = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   jensen_wake_deficit dut (.*);

   jensen_wake_deficit_chk chk (.*);

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Send one query, holding it until the transaction completes; push stays
   // high afterwards so that queries can follow back to back
   task automatic send_query(input logic [15:0] ct, input logic [15:0] u,
                             input logic [23:0] r, input logic [23:0] x,
                             input logic [23:0] t);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_push <= 0;
         repeat (g) @(posedge clock);
      end
      req_push            <= 1;
      req_thrust_coeff    <= ct;
      req_inflow_speed    <= u;
      req_rotor_radius    <= r;
      req_downstream_dist <= x;
      req_transverse_dist <= t;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Register write while the block is idle
   task automatic write_kexp(input logic [15:0] k);
      req_push <= 0;
      while (pending != 0) @(posedge clock);
      repeat (45) @(posedge clock);
      csr_valid          <= 1;
      csr_wake_expansion <= k;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   // Random query: mostly inside the wake with realistic geometry
   task automatic random_query();
      logic [15:0] ct, u;
      logic [23:0] r, x, t;
      int          p;
      ct = 16'($urandom);
      u  = 16'($urandom);
      p  = $urandom_range(99);
      if (p < 70) begin
         r = 24'($urandom_range(24'h8000, 1));
         x = 24'($urandom_range(24'h3FFFFF, 1));
         t = 24'($urandom_range(r + 3 * r));
      end else if (p < 85) begin
         r = 24'($urandom);
         x = 24'($urandom);
         t = 24'($urandom);
      end else begin
         r = ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom);
         u = ($urandom_range(3) == 0) ? 16'd0 : u;
         x = 24'($urandom);
         t = 24'($urandom_range(24'hFFFF));
      end
      send_query(ct, u, r, x, t);
   endtask

   // Result side: random pop stalls
   always @(posedge clock) begin
      if (reset) rsp_pop <= 0;
      else rsp_pop <= ($urandom_range(99) < 70) || send_done;
   end

   initial begin
      logic [15:0] ksets[5];
      int          n;
      ksets = '{16'd0, 16'd1, 16'hFFFF, 16'd30000, 16'd4915};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: extremes, edges and invalid inputs at the reset rate
      send_query(16'd0, 16'hFFFF, 24'd100, 24'd100, 24'd0);
      send_query(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'hFFFFFF);
      send_query(16'd30000, 16'd0, 24'd100, 24'd100, 24'd0);
      send_query(16'd30000, 16'd2560, 24'd0, 24'd100, 24'd0);
      send_query(16'd30000, 16'd2560, 24'd100, 24'd0, 24'd0);
      send_query(16'd30000, 16'd2560, 24'd100, 24'h800000, 24'd0);
      send_query(16'd30000, 16'd2560, 24'd100, 24'hFFFFFF, 24'd0);
      // exactly on the wake edge, then just outside: w = 100 + (4915*65536>>16)
      send_query(16'd52428, 16'd2560, 24'd100, 24'd65536, 24'd5015);
      send_query(16'd52428, 16'd2560, 24'd100, 24'd65536, 24'd5016);
      send_query(16'hFFFF, 16'd1, 24'd1, 24'd1, 24'd1);
      send_query(16'h5555, 16'hAAAA, 24'h555555, 24'h2AAAAA, 24'hAAAAAA);
      send_query(16'hAAAA, 16'h5555, 24'hAAAAAA, 24'h555555, 24'h555555);
      // Random phases over several expansion settings
      foreach (ksets[i]) begin
         write_kexp(ksets[i]);
         n = (i == 0) ? 100 : 430;
         repeat (n) random_query();
         if (i == 0) send_query(16'd1000, 16'd2560, 24'd100, 24'd100, 24'd0);
      end
      req_push <= 0;
      send_done = 1;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) $display("PASS jensen_wake_deficit");
      else $display("FAIL jensen_wake_deficit");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL jensen_wake_deficit");
      $finish;
   end
endmodule
